FILE: sv/lobm_pkg.sv
// ----------------------------------------------------------------------------
// lobm_pkg: shared types and constants of the limit order book matcher
// Request and status codes, sequencer states, default sizes and the
// widths of the stream payloads.
// ----------------------------------------------------------------------------
package lobm_pkg;

    // Default sizes
    localparam int ORDER_SLOTS_DEF = 64;
    localparam int PRICE_BITS_DEF  = 32;
    localparam int QTY_BITS_DEF    = 32;

    // Fixed field widths
    localparam int ID_W    = 32;
    localparam int FIELD_W = 32;
    localparam int SEQ_W   = 32;

    // Stream payload widths; the tdata widths are padded to whole bytes
    localparam int S_TDATA_W = 104;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 136;

    // Request kinds
    localparam logic [1:0] REQ_REST   = 2'd0;
    localparam logic [1:0] REQ_CANCEL = 2'd1;
    localparam logic [1:0] REQ_LIMIT  = 2'd2;
    localparam logic [1:0] REQ_MARKET = 2'd3;

    // Status codes
    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_DUP     = 2'd1;
    localparam logic [1:0] STAT_UNKNOWN = 2'd2;
    localparam logic [1:0] STAT_FULL    = 2'd3;

    // Order sides
    localparam logic SIDE_BUY  = 1'b0;
    localparam logic SIDE_SELL = 1'b1;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ID_SCAN,
        ST_BEST_SCAN,
        ST_FILL,
        ST_FINAL_SCAN,
        ST_REST,
        ST_DONE
    } lobm_state_t;

endpackage

FILE: sv/lobm_ram.sv
// ----------------------------------------------------------------------------
// lobm_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module lobm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: sv/limit_order_book_matcher.sv
// ----------------------------------------------------------------------------
// limit_order_book_matcher: price-time priority limit order book
// Keeps resting buy and sell orders in a slot RAM and serves rest, cancel,
// limit and market requests, one transaction at a time.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_ stream: tuser carries the request kind, tdata
//   the order id, side, price and quantity. Each request answers with one
//   transaction on the m_ stream: status, unfilled quantity, rested flag,
//   best bid, best ask and spread after the request.
//   Work is done by one sequencer that sweeps the slot RAM one slot per
//   cycle. The RAM read port is the limit. A rest or cancel takes two
//   sweeps. A limit request with k fills takes k+2 sweeps when its last
//   fill uses up the quantity, else k+3; a market request takes one sweep
//   fewer (one sweep for zero quantity). The next request is taken once
//   the sequencer has loaded the result register and returned to idle.
//   s_tready is high only while the sequencer is idle; a finished result
//   waits in the output register, and the next request is taken meanwhile.
//   If the receiver stalls while a result waits, the next result holds in
//   the sequencer until the output register frees.
//   Reset clears the valid bit of every slot and the arrival counter at
//   once; no clearing pass is needed and a request is taken right after.
// ----------------------------------------------------------------------------
module limit_order_book_matcher
    import lobm_pkg::*;
#(
    parameter int ORDER_SLOTS = ORDER_SLOTS_DEF,
    parameter int PRICE_BITS  = PRICE_BITS_DEF,
    parameter int QTY_BITS    = QTY_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // order_id[31:0], side[32], price[64:33], quantity[96:65], zero pad
    input  logic [S_TDATA_W-1:0] s_tdata,
    // req_type[1:0]
    input  logic [S_TUSER_W-1:0] s_tuser,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // status[1:0], unfilled_quantity[33:2], rested[34], best_bid[66:35],
    // best_ask[98:67], spread[130:99], zero pad
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready
);

    localparam int AW      = $clog2(ORDER_SLOTS);
    localparam int P       = PRICE_BITS;
    localparam int Q       = QTY_BITS;
    localparam int REC_W   = ID_W + 1 + P + Q + SEQ_W;
    localparam int OFF_SD  = ID_W;
    localparam int OFF_PR  = ID_W + 1;
    localparam int OFF_QT  = ID_W + 1 + P;
    localparam int OFF_SQ  = ID_W + 1 + P + Q;

    lobm_state_t state_reg, state_next;

    // request registers
    logic [1:0]       type_reg, type_next;
    logic [ID_W-1:0]  id_reg, id_next;
    logic             side_reg, side_next;
    logic [P-1:0]     price_reg, price_next;
    logic [Q-1:0]     left_reg, left_next;
    logic             rest_pend_reg, rest_pend_next;
    logic [1:0]       status_reg, status_next;
    logic             rested_reg, rested_next;

    // sweep control
    logic [AW:0]      cnt_reg, cnt_next;
    logic             rd_vld_reg, rd_vld_next;
    logic [AW-1:0]    rd_idx_reg, rd_idx_next;

    // id search
    logic             found_reg, found_next;
    logic [AW-1:0]    found_idx_reg, found_idx_next;

    // best opposite order
    logic             have_reg, have_next;
    logic [AW-1:0]    best_idx_reg, best_idx_next;
    logic [P-1:0]     best_price_reg, best_price_next;
    logic [Q-1:0]     best_qty_reg, best_qty_next;
    logic [SEQ_W-1:0] best_age_reg, best_age_next;
    logic [SEQ_W-1:0] best_seq_reg, best_seq_next;
    logic [ID_W-1:0]  best_id_reg, best_id_next;

    // book summary and free slot
    logic             bid_have_reg, bid_have_next;
    logic             ask_have_reg, ask_have_next;
    logic [P-1:0]     bid_reg, bid_next;
    logic [P-1:0]     ask_reg, ask_next;
    logic             free_have_reg, free_have_next;
    logic [AW-1:0]    free_idx_reg, free_idx_next;

    // book state
    logic [ORDER_SLOTS-1:0] valid_reg, valid_next;
    logic [SEQ_W-1:0]       arrival_reg, arrival_next;

    // result register
    logic             m_tvalid_reg, m_tvalid_next;
    logic [1:0]       o_status_reg, o_status_next;
    logic [FIELD_W-1:0] o_left_reg, o_left_next;
    logic             o_rested_reg, o_rested_next;
    logic [FIELD_W-1:0] o_bid_reg, o_bid_next;
    logic [FIELD_W-1:0] o_ask_reg, o_ask_next;
    logic [FIELD_W-1:0] o_spread_reg, o_spread_next;

    // RAM port signals
    logic             ram_wr_en;
    logic [AW-1:0]    ram_wr_addr;
    logic [REC_W-1:0] ram_wr_data;
    logic             ram_rd_en;
    logic [AW-1:0]    ram_rd_addr;
    logic [REC_W-1:0] ram_rd_data;

    // decoded fields
    logic             s_fire;
    logic             in_scan;
    logic             scan_done;
    logic             scan_start;
    logic             issue;
    logic             opp_side;
    logic             r_v;
    logic [ID_W-1:0]  r_id;
    logic             r_side;
    logic [P-1:0]     r_price;
    logic [Q-1:0]     r_qty;
    logic [SEQ_W-1:0] r_seq;
    logic [SEQ_W-1:0] r_age;
    logic             r_better;
    logic             lim_block;
    logic [Q-1:0]     fill_amt;
    logic [Q-1:0]     fill_left;
    logic [Q-1:0]     fill_rest;
    logic             rest_ok;
    logic             out_free;
    logic [P-1:0]     fin_bid;
    logic [P-1:0]     fin_ask;
    logic [P-1:0]     fin_spread;

    lobm_ram #(
        .WIDTH (REC_W),
        .DEPTH (ORDER_SLOTS)
    ) u_slot_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Decode the row under compare and the shared compare unit
    always_comb begin
        r_id     = ram_rd_data[ID_W-1:0];
        r_side   = ram_rd_data[OFF_SD];
        r_price  = ram_rd_data[OFF_PR +: P];
        r_qty    = ram_rd_data[OFF_QT +: Q];
        r_seq    = ram_rd_data[OFF_SQ +: SEQ_W];
        r_v      = valid_reg[rd_idx_reg];
        r_age    = arrival_reg - r_seq;
        opp_side = ~side_reg;
        if (!have_reg) begin
            r_better = 1'b1;
        end else if (r_price != best_price_reg) begin
            r_better = (opp_side == SIDE_BUY) ? (r_price > best_price_reg)
                                              : (r_price < best_price_reg);
        end else begin
            r_better = r_age > best_age_reg;
        end
    end

    // Sweep status, fill arithmetic and summary values
    always_comb begin
        s_fire    = s_tvalid && s_tready;
        in_scan   = (state_reg == ST_ID_SCAN) || (state_reg == ST_BEST_SCAN) ||
                    (state_reg == ST_FINAL_SCAN);
        issue     = in_scan && (cnt_reg < (AW+1)'(ORDER_SLOTS));
        scan_done = in_scan && (cnt_reg == (AW+1)'(ORDER_SLOTS)) && !rd_vld_reg;
        lim_block = (type_reg == REQ_LIMIT) && (price_reg != '0) &&
                    ((side_reg == SIDE_BUY) ? (best_price_reg > price_reg)
                                            : (best_price_reg < price_reg));
        fill_amt  = (left_reg < best_qty_reg) ? left_reg : best_qty_reg;
        fill_left = left_reg - fill_amt;
        fill_rest = best_qty_reg - fill_amt;
        rest_ok   = rest_pend_reg && (left_reg != '0) && free_have_reg;
        out_free  = !m_tvalid_reg || m_tready;
        fin_bid   = bid_have_reg ? bid_reg : '0;
        fin_ask   = ask_have_reg ? ask_reg : '0;
        fin_spread = (bid_have_reg && ask_have_reg && (ask_reg >= bid_reg)) ?
                     (ask_reg - bid_reg) : '0;
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    if (s_tuser[1:0] == REQ_MARKET) begin
                        state_next = (Q'(s_tdata[96:65]) == '0) ? ST_FINAL_SCAN
                                                                : ST_BEST_SCAN;
                    end else begin
                        state_next = ST_ID_SCAN;
                    end
                end
            end
            ST_ID_SCAN: begin
                if (scan_done) begin
                    if (type_reg == REQ_LIMIT && !found_reg && left_reg != '0) begin
                        state_next = ST_BEST_SCAN;
                    end else begin
                        state_next = ST_FINAL_SCAN;
                    end
                end
            end
            ST_BEST_SCAN: begin
                if (scan_done) begin
                    state_next = (!have_reg || lim_block) ? ST_FINAL_SCAN : ST_FILL;
                end
            end
            ST_FILL: begin
                state_next = (fill_left == '0) ? ST_FINAL_SCAN : ST_BEST_SCAN;
            end
            ST_FINAL_SCAN: begin
                if (scan_done) begin
                    state_next = ST_REST;
                end
            end
            ST_REST: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Handshake and RAM port controls
    always_comb begin
        s_tready    = (state_reg == ST_IDLE);
        ram_rd_en   = issue;
        ram_rd_addr = cnt_reg[AW-1:0];
        ram_wr_en   = 1'b0;
        ram_wr_addr = best_idx_reg;
        ram_wr_data = {best_seq_reg, fill_rest, best_price_reg, opp_side, best_id_reg};
        case (state_reg)
            ST_FILL: begin
                ram_wr_en = (fill_rest != '0);
            end
            ST_REST: begin
                ram_wr_en   = rest_ok;
                ram_wr_addr = free_idx_reg;
                ram_wr_data = {arrival_reg, left_reg, price_reg, side_reg, id_reg};
            end
            default: begin
                ram_wr_en = 1'b0;
            end
        endcase
    end

    // Datapath next values
    always_comb begin
        type_next       = type_reg;
        id_next         = id_reg;
        side_next       = side_reg;
        price_next      = price_reg;
        left_next       = left_reg;
        rest_pend_next  = rest_pend_reg;
        status_next     = status_reg;
        rested_next     = rested_reg;
        cnt_next        = cnt_reg;
        rd_vld_next     = rd_vld_reg;
        rd_idx_next     = rd_idx_reg;
        found_next      = found_reg;
        found_idx_next  = found_idx_reg;
        have_next       = have_reg;
        best_idx_next   = best_idx_reg;
        best_price_next = best_price_reg;
        best_qty_next   = best_qty_reg;
        best_age_next   = best_age_reg;
        best_seq_next   = best_seq_reg;
        best_id_next    = best_id_reg;
        bid_have_next   = bid_have_reg;
        ask_have_next   = ask_have_reg;
        bid_next        = bid_reg;
        ask_next        = ask_reg;
        free_have_next  = free_have_reg;
        free_idx_next   = free_idx_reg;
        valid_next      = valid_reg;
        arrival_next    = arrival_reg;
        m_tvalid_next   = m_tvalid_reg;
        o_status_next   = o_status_reg;
        o_left_next     = o_left_reg;
        o_rested_next   = o_rested_reg;
        o_bid_next      = o_bid_reg;
        o_ask_next      = o_ask_reg;
        o_spread_next   = o_spread_reg;

        // drop the result once taken
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        // capture a request
        if (s_fire) begin
            type_next      = s_tuser[1:0];
            id_next        = s_tdata[31:0];
            side_next      = s_tdata[32];
            price_next     = P'(s_tdata[64:33]);
            left_next      = (s_tuser[1:0] == REQ_CANCEL) ? '0 : Q'(s_tdata[96:65]);
            rest_pend_next = 1'b0;
            status_next    = STAT_OK;
            rested_next    = 1'b0;
        end

        // advance the sweep one slot
        if (in_scan) begin
            cnt_next    = issue ? cnt_reg + 1'b1 : cnt_reg;
            rd_vld_next = issue;
            rd_idx_next = cnt_reg[AW-1:0];
        end

        // compare the row read last cycle
        if (rd_vld_reg && r_v) begin
            case (state_reg)
                ST_ID_SCAN: begin
                    if (r_id == id_reg && !found_reg) begin
                        found_next     = 1'b1;
                        found_idx_next = rd_idx_reg;
                    end
                end
                ST_BEST_SCAN: begin
                    if (r_side == opp_side && r_better) begin
                        have_next       = 1'b1;
                        best_idx_next   = rd_idx_reg;
                        best_price_next = r_price;
                        best_qty_next   = r_qty;
                        best_age_next   = r_age;
                        best_seq_next   = r_seq;
                        best_id_next    = r_id;
                    end
                end
                ST_FINAL_SCAN: begin
                    if (r_side == SIDE_BUY) begin
                        if (!bid_have_reg || r_price > bid_reg) begin
                            bid_next = r_price;
                        end
                        bid_have_next = 1'b1;
                    end else begin
                        if (!ask_have_reg || r_price < ask_reg) begin
                            ask_next = r_price;
                        end
                        ask_have_next = 1'b1;
                    end
                end
                default: begin
                    found_next = found_reg;
                end
            endcase
        end

        // take the first free slot in the final sweep
        if (state_reg == ST_FINAL_SCAN && rd_vld_reg && !r_v && !free_have_reg) begin
            free_have_next = 1'b1;
            free_idx_next  = rd_idx_reg;
        end

        // settle the id search
        if (state_reg == ST_ID_SCAN && scan_done) begin
            if (type_reg == REQ_CANCEL) begin
                if (found_reg) begin
                    valid_next[found_idx_reg] = 1'b0;
                end else begin
                    status_next = STAT_UNKNOWN;
                end
            end else if (found_reg) begin
                status_next = STAT_DUP;
            end else begin
                rest_pend_next = 1'b1;
            end
        end

        // apply one fill
        if (state_reg == ST_FILL) begin
            left_next = fill_left;
            if (fill_rest == '0) begin
                valid_next[best_idx_reg] = 1'b0;
            end
        end

        // rest the remainder and fold it into the summary, else flag a full book
        if (state_reg == ST_REST && rest_pend_reg && left_reg != '0) begin
            if (free_have_reg) begin
                valid_next[free_idx_reg] = 1'b1;
                arrival_next             = arrival_reg + 1'b1;
                rested_next              = 1'b1;
                if (side_reg == SIDE_BUY) begin
                    if (!bid_have_reg || price_reg > bid_reg) begin
                        bid_next = price_reg;
                    end
                    bid_have_next = 1'b1;
                end else begin
                    if (!ask_have_reg || price_reg < ask_reg) begin
                        ask_next = price_reg;
                    end
                    ask_have_next = 1'b1;
                end
            end else begin
                status_next = STAT_FULL;
            end
        end

        // load the result register
        if (state_reg == ST_DONE && out_free) begin
            m_tvalid_next = 1'b1;
            o_status_next = status_reg;
            o_left_next   = FIELD_W'(left_reg);
            o_rested_next = rested_reg;
            o_bid_next    = FIELD_W'(fin_bid);
            o_ask_next    = FIELD_W'(fin_ask);
            o_spread_next = FIELD_W'(fin_spread);
        end

        // clear the sweep accumulators on entry to a sweep
        if (scan_start) begin
            cnt_next       = '0;
            rd_vld_next    = 1'b0;
            found_next     = 1'b0;
            have_next      = 1'b0;
            bid_have_next  = 1'b0;
            ask_have_next  = 1'b0;
            free_have_next = 1'b0;
        end
    end

    assign scan_start = (state_next != state_reg) &&
                        ((state_next == ST_ID_SCAN) || (state_next == ST_BEST_SCAN) ||
                         (state_next == ST_FINAL_SCAN));

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            valid_reg     <= '0;
            arrival_reg   <= '0;
            m_tvalid_reg  <= 1'b0;
            cnt_reg       <= '0;
            rd_vld_reg    <= 1'b0;
        end else begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            arrival_reg   <= arrival_next;
            m_tvalid_reg  <= m_tvalid_next;
            cnt_reg       <= cnt_next;
            rd_vld_reg    <= rd_vld_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        type_reg       <= type_next;
        id_reg         <= id_next;
        side_reg       <= side_next;
        price_reg      <= price_next;
        left_reg       <= left_next;
        rest_pend_reg  <= rest_pend_next;
        status_reg     <= status_next;
        rested_reg     <= rested_next;
        rd_idx_reg     <= rd_idx_next;
        found_reg      <= found_next;
        found_idx_reg  <= found_idx_next;
        have_reg       <= have_next;
        best_idx_reg   <= best_idx_next;
        best_price_reg <= best_price_next;
        best_qty_reg   <= best_qty_next;
        best_age_reg   <= best_age_next;
        best_seq_reg   <= best_seq_next;
        best_id_reg    <= best_id_next;
        bid_have_reg   <= bid_have_next;
        ask_have_reg   <= ask_have_next;
        bid_reg        <= bid_next;
        ask_reg        <= ask_next;
        free_have_reg  <= free_have_next;
        free_idx_reg   <= free_idx_next;
        o_status_reg   <= o_status_next;
        o_left_reg     <= o_left_next;
        o_rested_reg   <= o_rested_next;
        o_bid_reg      <= o_bid_next;
        o_ask_reg      <= o_ask_next;
        o_spread_reg   <= o_spread_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'b0, o_spread_reg, o_ask_reg, o_bid_reg, o_rested_reg,
                       o_left_reg, o_status_reg};

    // Book contents never change while the sequencer is idle
    a_idle_book_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |=> $stable(valid_reg))
        else $error("slot valid bits changed while idle");

    // The arrival counter advances only when an order comes to rest
    a_arrival_only_on_rest: assert property (@(posedge aclk) disable iff (!aresetn)
        !(state_reg == ST_REST && rest_ok) |=> $stable(arrival_reg))
        else $error("arrival counter moved without a rested order");

    // A fill always has something to take and something to give
    a_fill_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FILL) |-> (left_reg != '0 && best_qty_reg != '0))
        else $error("fill step entered with zero quantity");

    // A rejected request never reports a rested order
    a_reject_not_rested: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && o_status_reg != STAT_OK) |-> !o_rested_reg)
        else $error("rejected request reported as rested");

endmodule

FILE: sim/limit_order_book_matcher_tb.sv
// ----------------------------------------------------------------------------
// limit_order_book_matcher_tb: self-checking bench of the order book matcher
// Drives rest, cancel, limit and market requests with random idling on both
// streams and checks every response against a price-time priority book model.
// ----------------------------------------------------------------------------
module limit_order_book_matcher_tb;
    import lobm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS     = ORDER_SLOTS_DEF;
    localparam int N_RANDOM  = 1900;
    localparam int CYC_LIMIT = 20000000;

    // Response fields, last field in the top bits as on m_tdata
    typedef struct packed {
        logic [31:0] spread;
        logic [31:0] ask;
        logic [31:0] bid;
        logic        rested;
        logic [31:0] left;
        logic [1:0]  status;
    } book_resp_t;

    // Book model with a queue of expected responses
    class book_scoreboard;
        bit          valid [SLOTS];
        logic [31:0] id    [SLOTS];
        logic        side  [SLOTS];
        logic [31:0] price [SLOTS];
        logic [31:0] qty   [SLOTS];
        logic [31:0] seq   [SLOTS];
        logic [31:0] arrivals;
        book_resp_t  pending[$];
        int          mismatches;

        function void clear();
            foreach (valid[i]) valid[i] = 0;
            arrivals = 0;
            pending.delete();
            mismatches = 0;
        endfunction

        function int find_id(logic [31:0] k);
            foreach (valid[i]) if (valid[i] && id[i] == k) return i;
            return -1;
        endfunction

        function int find_free();
            foreach (valid[i]) if (!valid[i]) return i;
            return -1;
        endfunction

        function int find_best(logic s);
            int b;
            logic [31:0] ai, ab;
            b = -1;
            foreach (valid[i]) begin
                if (!valid[i] || side[i] != s) continue;
                if (b < 0) begin
                    b = i;
                end else if (price[i] != price[b]) begin
                    if (s == SIDE_BUY ? price[i] > price[b] : price[i] < price[b]) b = i;
                end else begin
                    ai = arrivals - seq[i];
                    ab = arrivals - seq[b];
                    if (ai > ab) b = i;
                end
            end
            return b;
        endfunction

        // Sweep the opposite side, best price and oldest first
        function logic [31:0] sweep(logic s, logic [31:0] q, logic [31:0] lim);
            int b;
            logic [31:0] f;
            for (int n = 0; n <= SLOTS && q > 0; n++) begin
                b = find_best(~s);
                if (b < 0) break;
                if (lim != 0) begin
                    if (s == SIDE_BUY && price[b] > lim) break;
                    if (s == SIDE_SELL && price[b] < lim) break;
                end
                f = q < qty[b] ? q : qty[b];
                q -= f;
                qty[b] -= f;
                if (qty[b] == 0) valid[b] = 0;
            end
            return q;
        endfunction

        function void note_request(logic [1:0] kind, logic [31:0] oid, logic s,
                                   logic [31:0] p, logic [31:0] q);
            book_resp_t r;
            int k, bb, ba;
            r = '0;
            if (kind == REQ_CANCEL) begin
                k = find_id(oid);
                if (k < 0) r.status = STAT_UNKNOWN;
                else valid[k] = 0;
            end else if (kind == REQ_MARKET) begin
                r.left = sweep(s, q, 0);
            end else if (find_id(oid) >= 0) begin
                r.status = STAT_DUP;
                r.left = q;
            end else begin
                r.left = (kind == REQ_LIMIT) ? sweep(s, q, p) : q;
                if (r.left > 0) begin
                    k = find_free();
                    if (k < 0) begin
                        r.status = STAT_FULL;
                    end else begin
                        valid[k] = 1; id[k] = oid; side[k] = s; price[k] = p;
                        qty[k] = r.left; seq[k] = arrivals;
                        arrivals++;
                        r.rested = 1;
                    end
                end
            end
            bb = find_best(SIDE_BUY);
            ba = find_best(SIDE_SELL);
            if (bb >= 0) r.bid = price[bb];
            if (ba >= 0) r.ask = price[ba];
            if (bb >= 0 && ba >= 0 && r.ask >= r.bid) r.spread = r.ask - r.bid;
            pending = {pending, r};
        endfunction

        function void check_response(book_resp_t got);
            book_resp_t e;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected response %h", got);
                return;
            end
            e = pending[0];
            pending.delete(0);
            if (got !== e) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp st=%0d left=%0d r=%0d bid=%0d ask=%0d spr=%0d",
                             e.status, e.left, e.rested, e.bid, e.ask, e.spread,
                             " got st=%0d left=%0d r=%0d bid=%0d ask=%0d spr=%0d",
                             got.status, got.left, got.rested, got.bid, got.ask,
                             got.spread);
            end
        endfunction
    endclass

    logic                 aclk = 0;
    logic                 aresetn = 0;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [S_TUSER_W-1:0] s_tuser = '0;
    logic                 s_tvalid = 0;
    logic                 s_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tvalid;
    logic                 m_tready = 0;

    book_scoreboard book = new();
    bit             calm = 0;
    int             cycles = 0;
    logic [31:0]    used_ids[$];

    limit_order_book_matcher dut (.*);

    always #2 aclk = ~aclk;

    // Bound the run
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYC_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Stall the receiver at random; check each response transaction
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            book.check_response(book_resp_t'(m_tdata[130:0]));
        m_tready <= calm || ($urandom_range(99) >= 21);
    end

    // Send one request transaction, with random idle cycles ahead of it
    task automatic send_req(logic [1:0] kind, logic [31:0] oid, logic s,
                            logic [31:0] p, logic [31:0] q);
        while (!calm && $urandom_range(99) < 21) begin
            s_tvalid <= 0;
            @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tuser  <= kind;
        s_tdata  <= {7'd0, q, p, s, oid};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        book.note_request(kind, oid, s, p, q);
        used_ids = {used_ids, oid};
    endtask

    function automatic logic [31:0] pick_id();
        if (used_ids.size() > 0 && $urandom_range(99) < 40)
            return used_ids[$urandom_range(used_ids.size() - 1)];
        return $urandom_range(199);
    endfunction

    initial begin
        logic [1:0]  kind;
        logic [31:0] p, q;
        int          r;
        book.clear();
        repeat (4) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Directed: empty book, extremes, duplicates, cancels, crossing
        send_req(REQ_CANCEL, 32'd5, SIDE_BUY, 0, 0);
        send_req(REQ_MARKET, 32'd1, SIDE_BUY, 0, 100);
        send_req(REQ_REST, 32'd1, SIDE_BUY, 32'd100, 32'd10);
        send_req(REQ_REST, 32'd1, SIDE_SELL, 32'd200, 32'd10);
        send_req(REQ_REST, 32'd2, SIDE_SELL, 32'd200, 32'd5);
        send_req(REQ_REST, 32'd3, SIDE_SELL, 32'd200, 32'd7);
        send_req(REQ_REST, 32'd4, SIDE_BUY, 32'd50, 32'd0);
        send_req(REQ_LIMIT, 32'd9, SIDE_BUY, 32'd200, 32'd8);
        send_req(REQ_LIMIT, 32'd10, SIDE_SELL, 32'd90, 32'd20);
        send_req(REQ_REST, 32'd11, SIDE_SELL, 32'd0, 32'd3);
        send_req(REQ_REST, 32'hFFFF_FFFF, SIDE_BUY, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_req(REQ_MARKET, 32'd12, SIDE_SELL, 32'd0, 32'hFFFF_FFFF);
        send_req(REQ_LIMIT, 32'd13, SIDE_BUY, 32'd0, 32'd4);
        send_req(REQ_CANCEL, 32'd11, SIDE_SELL, 0, 0);
        send_req(REQ_CANCEL, 32'd1, SIDE_BUY, 0, 0);
        // Fill the book to trigger the full case, then drain it
        for (int i = 0; i < SLOTS + 2; i++)
            send_req(REQ_REST, 32'd1000 + i, i[0], 32'd500 + i[0] * 32'd10, 32'd1);
        send_req(REQ_LIMIT, 32'd2000, SIDE_BUY, 32'd1, 32'd5);
        send_req(REQ_MARKET, 32'd2001, SIDE_BUY, 32'd0, 32'd1000);
        send_req(REQ_MARKET, 32'd2002, SIDE_SELL, 32'd0, 32'd1000);

        // Random: mostly prices near a mid and small sizes, some wide values
        for (int n = 0; n < N_RANDOM; n++) begin
            calm = (n >= 800 && n < 1000);
            r = $urandom_range(99);
            kind = r < 35 ? REQ_REST : r < 55 ? REQ_CANCEL : r < 88 ? REQ_LIMIT : REQ_MARKET;
            p = $urandom_range(99) < 8 ? $urandom() : $urandom_range(1020, 980);
            if ($urandom_range(99) < 4) p = 0;
            q = $urandom_range(99) < 8 ? $urandom() : $urandom_range(20);
            send_req(kind, pick_id(), $urandom_range(1), p, q);
            if (used_ids.size() > 300) used_ids.delete(0);
        end
        s_tvalid <= 0;

        // Drain outstanding responses
        calm = 1;
        while (book.pending.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (book.mismatches == 0 && book.pending.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
